// File: rtl/pflr_pkg.sv
// ----------------------------------------------------------------------------
// pflr_pkg
// Shared types and constants of the LFU page fault replacer.
// ----------------------------------------------------------------------------
`default_nettype none

package pflr_pkg;

	// default sizes
	localparam int SLOTS_DEF          = 32;
	localparam int HEAP_PAGES_MAX_DEF = 1024;

	// configuration register
	localparam int          CFG_W          = 11;
	localparam logic [10:0] HEAP_PAGES_RST = 11'd1024;

	// field widths
	localparam int FSW_W      = 11;
	localparam int ADDR_W     = 32;
	localparam int VSLOT_W    = 5;
	localparam int PAGE_OUT_W = 10;
	localparam int PADDR_W    = 26;
	localparam int CNT_W      = 16;

	// stream words
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 56;

	// heap window
	localparam logic [31:0] WIN_BASE = 32'h0200_0000;
	localparam int          PG_SHIFT = 13;

	// decoded fault status codes
	localparam logic [4:0] ST_SECTION = 5'h05;
	localparam logic [4:0] ST_PAGE    = 5'h07;

	// sequencer
	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_BUMP  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	// control to the minimum unit
	typedef struct packed {
		logic valid;
		logic first;
	} cmp_ctl_t;

endpackage

`default_nettype wire

// File: rtl/pflr_ram.sv
// ----------------------------------------------------------------------------
// pflr_ram
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pflr_ram #(
	parameter int W = 16,
	parameter int D = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/pflr_min_unit.sv
// ----------------------------------------------------------------------------
// pflr_min_unit
// Running minimum over the scanned slot counts; lowest slot wins ties.
// ----------------------------------------------------------------------------
`default_nettype none

module pflr_min_unit #(
	parameter int SW = 5,
	parameter int PW = 10
) (
	input  wire logic                       clk,
	input  wire pflr_pkg::cmp_ctl_t         ctl,
	input  wire logic [pflr_pkg::CNT_W-1:0] count,
	input  wire logic [SW-1:0]              slot,
	input  wire logic [PW-1:0]              page,
	output logic      [SW-1:0]              best_slot,
	output logic      [PW-1:0]              best_page
);

	logic [pflr_pkg::CNT_W-1:0] best_cnt_q;
	logic [SW-1:0]              best_slot_q;
	logic [PW-1:0]              best_page_q;

	// strict less keeps the earlier slot on a tie
	always_ff @(posedge clk) begin
		if (ctl.valid && (ctl.first || count < best_cnt_q)) begin
			best_cnt_q  <= count;
			best_slot_q <= slot;
			best_page_q <= page;
		end
	end

	assign best_slot = best_slot_q;
	assign best_page = best_page_q;

endmodule

`default_nettype wire

// File: rtl/page_fault_lfu_replacer.sv
// Flow: an accepted fault that is ignored goes straight to the done state and
// m_axis_tvalid is registered from there; a handled fault first runs a serial
// slot scan through the count memory read port, then three counter updates.
// Throughput: one fault at a time; s_axis_tready is high only while idle.
// Reset: arst_n clears control at once, then a clearing pass over every slot
// and counter address loads slot pages and zeroes counters.
// ----------------------------------------------------------------------------
// page_fault_lfu_replacer
// Least-frequently-used page replacement for faults inside a paged heap window.
// ----------------------------------------------------------------------------
`default_nettype none

module page_fault_lfu_replacer #(
	parameter int SLOTS          = pflr_pkg::SLOTS_DEF,
	parameter int HEAP_PAGES_MAX = pflr_pkg::HEAP_PAGES_MAX_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pflr_pkg::CFG_W-1:0]       cfg_wdata,     // heap_pages
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// fault_status_word [10:0], fault_address [42:11]
	input  wire logic [pflr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  wire logic                             s_axis_tuser,  // is_data_abort
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// victim_slot [4:0], evicted_page [14:5], loaded_page [24:15],
	// loaded_page_address [50:25]
	output logic      [pflr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                                  m_axis_tuser   // handled
);

	localparam int SW        = $clog2(SLOTS);
	localparam int SW1       = SW + 1;
	localparam int PGW       = $clog2(HEAP_PAGES_MAX);
	localparam int PW        = (PGW > SW) ? PGW : SW;
	localparam int CLR_DEPTH = (HEAP_PAGES_MAX > SLOTS) ? HEAP_PAGES_MAX : SLOTS;
	localparam int CLW       = $clog2(CLR_DEPTH);
	localparam int CW        = pflr_pkg::CNT_W;

	pflr_pkg::state_t state_q;

	logic [pflr_pkg::CFG_W-1:0] heap_pages_q;
	logic [pflr_pkg::CFG_W-1:0] eff_pages;

	logic [CLW-1:0] clr_q;
	logic [SW1-1:0] scan_q;
	logic [SW1-1:0] active_q;
	logic [1:0]     bstep_q;
	logic           handled_q;
	logic [PGW-1:0] page_q;

	// scan pipeline
	logic           v1_q, v2_q;
	logic [SW-1:0]  idx1_q, idx2_q;
	logic [PW-1:0]  page2_q;
	logic           stale2_q;
	logic           issue;
	logic           scan_done;

	// bump pipeline
	logic           bv1_q;
	logic [PGW-1:0] baddr1_q;
	logic [PGW-1:0] bump_addr;
	logic           bump_en;

	// memories
	logic           slot_we;
	logic [SW-1:0]  slot_waddr;
	logic [PW-1:0]  slot_wdata;
	logic [PW-1:0]  slot_rdata;
	logic           cnt_we;
	logic [PGW-1:0] cnt_waddr;
	logic [CW-1:0]  cnt_wdata;
	logic [PGW-1:0] cnt_raddr;
	logic [CW-1:0]  cnt_rdata;

	pflr_pkg::cmp_ctl_t cmp_ctl;
	logic [CW-1:0]      cmp_count;
	logic [SW-1:0]      best_slot;
	logic [PW-1:0]      best_page;

	// input decode
	logic [pflr_pkg::FSW_W-1:0]  fsw;
	logic [pflr_pkg::ADDR_W-1:0] faddr;
	logic [pflr_pkg::ADDR_W-1:0] foff;
	logic [4:0]                  fstatus;
	logic                        in_win;
	logic                        hit;
	logic                        accept;
	logic                        out_load;
	logic [pflr_pkg::ADDR_W-1:0] load_addr;

	assign eff_pages = (32'(heap_pages_q) > 32'(HEAP_PAGES_MAX)) ?
		pflr_pkg::CFG_W'(HEAP_PAGES_MAX) : heap_pages_q;

	assign fsw     = s_axis_tdata[10:0];
	assign faddr   = s_axis_tdata[42:11];
	assign foff    = faddr - pflr_pkg::WIN_BASE;
	assign fstatus = {fsw[10], fsw[3:0]};
	assign in_win  = (faddr >= pflr_pkg::WIN_BASE) &&
		((foff >> pflr_pkg::PG_SHIFT) < 32'(eff_pages));
	assign hit     = s_axis_tuser && in_win &&
		(fstatus == pflr_pkg::ST_SECTION || fstatus == pflr_pkg::ST_PAGE);

	assign s_axis_tready = (state_q == pflr_pkg::S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == pflr_pkg::S_DONE) && (!m_axis_tvalid || m_axis_tready);

	assign issue     = (state_q == pflr_pkg::S_SCAN) && (scan_q < active_q);
	assign scan_done = (state_q == pflr_pkg::S_SCAN) && (scan_q == active_q) && !v1_q && !v2_q;

	always_comb begin
		bump_addr = page_q;
		bump_en   = 1'b1;
		unique case (bstep_q)
			2'd0: begin
				bump_addr = page_q - PGW'(1);
				bump_en   = (page_q != '0);
			end
			2'd1: begin
				bump_addr = page_q;
				bump_en   = 1'b1;
			end
			2'd2: begin
				bump_addr = page_q + PGW'(1);
				bump_en   = (32'(page_q) + 32'd1) < 32'(eff_pages);
			end
			default: begin
				bump_addr = page_q;
				bump_en   = 1'b0;
			end
		endcase
	end

	// memory port selection
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = best_slot;
		slot_wdata = PW'(page_q);
		cnt_we     = bv1_q;
		cnt_waddr  = baddr1_q;
		cnt_wdata  = cnt_rdata + CW'(1);
		if (state_q == pflr_pkg::S_CLEAR) begin
			slot_we    = 32'(clr_q) < 32'(SLOTS);
			slot_waddr = SW'(clr_q);
			slot_wdata = PW'(clr_q);
			cnt_we     = 32'(clr_q) < 32'(HEAP_PAGES_MAX);
			cnt_waddr  = PGW'(clr_q);
			cnt_wdata  = '0;
		end else if (state_q == pflr_pkg::S_BUMP && bstep_q == 2'd3) begin
			slot_we = 1'b1;
		end
	end

	assign cnt_raddr = (state_q == pflr_pkg::S_SCAN) ? PGW'(slot_rdata) : bump_addr;

	pflr_ram #(.W(PW), .D(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (scan_q[SW-1:0]),
		.rdata (slot_rdata)
	);

	pflr_ram #(.W(CW), .D(HEAP_PAGES_MAX)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	assign cmp_ctl.valid = v2_q;
	assign cmp_ctl.first = (idx2_q == '0);
	assign cmp_count     = stale2_q ? '0 : cnt_rdata;

	pflr_min_unit #(.SW(SW), .PW(PW)) u_min (
		.clk       (clk),
		.ctl       (cmp_ctl),
		.count     (cmp_count),
		.slot      (idx2_q),
		.page      (page2_q),
		.best_slot (best_slot),
		.best_page (best_page)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pflr_pkg::S_CLEAR;
			heap_pages_q <= pflr_pkg::HEAP_PAGES_RST;
			clr_q        <= '0;
			scan_q       <= '0;
			bstep_q      <= '0;
			v1_q         <= 1'b0;
			v2_q         <= 1'b0;
			bv1_q        <= 1'b0;
			handled_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				heap_pages_q <= cfg_wdata;
			end
			v1_q  <= issue;
			v2_q  <= v1_q;
			bv1_q <= (state_q == pflr_pkg::S_BUMP) && bump_en;
			unique case (state_q)
				pflr_pkg::S_CLEAR: begin
					clr_q <= clr_q + CLW'(1);
					if (32'(clr_q) == CLR_DEPTH - 1) begin
						state_q <= pflr_pkg::S_IDLE;
					end
				end
				pflr_pkg::S_IDLE: begin
					if (accept) begin
						handled_q <= hit;
						scan_q    <= '0;
						state_q   <= hit ? pflr_pkg::S_SCAN : pflr_pkg::S_DONE;
					end
				end
				pflr_pkg::S_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + SW1'(1);
					end
					if (scan_done) begin
						bstep_q <= '0;
						state_q <= pflr_pkg::S_BUMP;
					end
				end
				pflr_pkg::S_BUMP: begin
					bstep_q <= bstep_q + 2'd1;
					if (bstep_q == 2'd3) begin
						state_q <= pflr_pkg::S_DONE;
					end
				end
				pflr_pkg::S_DONE: begin
					if (out_load) begin
						state_q <= pflr_pkg::S_IDLE;
					end
				end
				default: state_q <= pflr_pkg::S_IDLE;
			endcase
		end
	end

	// per-item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q   <= PGW'(foff >> pflr_pkg::PG_SHIFT);
			active_q <= (32'(eff_pages) < 32'(SLOTS)) ? SW1'(eff_pages) : SW1'(SLOTS);
		end
		idx1_q   <= scan_q[SW-1:0];
		idx2_q   <= idx1_q;
		page2_q  <= slot_rdata;
		stale2_q <= 32'(slot_rdata) >= 32'(HEAP_PAGES_MAX);
		baddr1_q <= bump_addr;
	end

	// output register
	assign load_addr = pflr_pkg::WIN_BASE + (32'(page_q) << pflr_pkg::PG_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tuser <= handled_q;
			if (handled_q) begin
				m_axis_tdata <= {5'b0,
					load_addr[pflr_pkg::PADDR_W-1:0],
					pflr_pkg::PAGE_OUT_W'(page_q),
					pflr_pkg::PAGE_OUT_W'(best_page),
					pflr_pkg::VSLOT_W'(best_slot)};
			end else begin
				m_axis_tdata <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/pflr_checker.sv
// ----------------------------------------------------------------------------
// pflr_checker
// Port-level checks of the LFU page fault replacer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pflr_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [pflr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                             m_axis_tuser
);

	// an ignored fault reports all-zero fields
	a_ignored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("ignored fault carries nonzero fields");

	// loaded address is the window base plus the loaded page
	a_addr_page: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
		(m_axis_tdata[37:25] == '0 && m_axis_tdata[47:38] == m_axis_tdata[24:15] &&
		 m_axis_tdata[50] == 1'b1 && m_axis_tdata[55:51] == '0))
		else $error("loaded page address does not match loaded page");

	// one fault at a time: busy right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready right after acceptance");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled output word changed");

endmodule

bind page_fault_lfu_replacer pflr_checker u_pflr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the LFU page fault replacer. Fault words go in through
// a queue-fed driver; a monitor predicts each result (victim choice, counter
// bumps, slot update) and checks every returned word against it. Heap size is
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int CYCLE_LIMIT    = 300000;
	localparam int ITEMS_PER_SIZE = 60;
	localparam int NUM_SIZES      = 8;
	localparam int PG_MAX         = pflr_pkg::HEAP_PAGES_MAX_DEF;
	localparam int NSLOTS         = pflr_pkg::SLOTS_DEF;

	typedef struct packed {
		logic                        abort;
		logic [pflr_pkg::FSW_W-1:0]  fsw;
		logic [pflr_pkg::ADDR_W-1:0] addr;
	} fault_word_t;

	typedef struct packed {
		logic                            handled;
		logic [pflr_pkg::VSLOT_W-1:0]    victim_slot;
		logic [pflr_pkg::PAGE_OUT_W-1:0] evicted_page;
		logic [pflr_pkg::PAGE_OUT_W-1:0] loaded_page;
		logic [pflr_pkg::PADDR_W-1:0]    page_addr;
	} swap_result_t;

	logic                             clk            = 1'b0;
	logic                             arst_n         = 1'b0;
	logic                             cfg_we         = 1'b0;
	logic [pflr_pkg::CFG_W-1:0]       cfg_wdata      = '0;
	logic                             s_axis_tvalid  = 1'b0;
	logic                             s_axis_tready;
	logic [pflr_pkg::IN_TDATA_W-1:0]  s_axis_tdata   = '0;
	logic                             s_axis_tuser   = 1'b0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready  = 1'b0;
	logic [pflr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             m_axis_tuser;

	// predictor state
	logic [pflr_pkg::PAGE_OUT_W-1:0] slot_pg [NSLOTS];
	logic [pflr_pkg::CNT_W-1:0]      miss_cnt [PG_MAX];
	logic [pflr_pkg::CFG_W-1:0]      heap_pages_model;

	fault_word_t  fault_pending[$];
	swap_result_t swaps_expected[$];
	fault_word_t  drv_word;

	logic in_fire      = 1'b0;
	int   items_issued = 0;
	int   results_seen = 0;
	int   swaps_seen   = 0;
	int   errors       = 0;
	int   cycle_count  = 0;
	int   hold_left    = 0;
	logic hold_done    = 1'b0;
	logic quiet;

	int heap_sizes [NUM_SIZES] = '{1024, 0, 1, 2047, 2, 31, 33, 700};

	assign quiet = (results_seen >= 250) && (results_seen < 350);

	page_fault_lfu_replacer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic void bump_miss_count(int unsigned p, int unsigned pages);
		if (p < pages && p < PG_MAX)
			miss_cnt[p] = miss_cnt[p] + 1'b1;
	endfunction

	function automatic swap_result_t predict_fault_swap(fault_word_t f);
		swap_result_t r;
		int unsigned  pages, act, victim, i, page;
		logic [4:0]   status;
		logic [32:0]  win_end;
		logic [15:0]  best, c;
		logic [9:0]   evicted;
		r = '0;
		pages = (heap_pages_model > PG_MAX) ? PG_MAX : heap_pages_model;
		status = {f.fsw[10], f.fsw[3:0]};
		win_end = {1'b0, pflr_pkg::WIN_BASE} + (33'(pages) << pflr_pkg::PG_SHIFT);
		if (!f.abort || (status != pflr_pkg::ST_SECTION && status != pflr_pkg::ST_PAGE))
			return r;
		if (f.addr < pflr_pkg::WIN_BASE || {1'b0, f.addr} >= win_end)
			return r;
		page = (f.addr - pflr_pkg::WIN_BASE) >> pflr_pkg::PG_SHIFT;
		act = (pages < NSLOTS) ? pages : NSLOTS;
		// counts from before this fault; strict less keeps the lowest slot on ties
		victim = 0;
		best = miss_cnt[slot_pg[0]];
		for (i = 1; i < act; i++) begin
			c = miss_cnt[slot_pg[i]];
			if (c < best) begin
				best = c;
				victim = i;
			end
		end
		bump_miss_count(page, pages);
		if (page > 0)
			bump_miss_count(page - 1, pages);
		bump_miss_count(page + 1, pages);
		evicted = slot_pg[victim];
		slot_pg[victim] = page[9:0];
		r.handled      = 1'b1;
		r.victim_slot  = victim[4:0];
		r.evicted_page = evicted;
		r.loaded_page  = page[9:0];
		r.page_addr    = 26'(pflr_pkg::WIN_BASE + (page << pflr_pkg::PG_SHIFT));
		return r;
	endfunction

	// mostly well-formed faults into the window, some broken, some pure noise
	function automatic fault_word_t make_fault(int pages);
		fault_word_t f;
		int          eff, page, kind;
		logic [32:0] win_end;
		eff = (pages > PG_MAX) ? PG_MAX : pages;
		if (eff == 0)
			eff = 1;
		win_end = {1'b0, pflr_pkg::WIN_BASE} + (33'(eff) << pflr_pkg::PG_SHIFT);
		if ($urandom_range(0, 1) == 1)
			page = $urandom_range(0, ((eff < 48) ? eff : 48) - 1);
		else
			page = $urandom_range(0, eff - 1);
		f.abort = 1'b1;
		f.fsw   = {1'b0, 6'($urandom), ($urandom_range(0, 1) == 1) ? 4'h5 : 4'h7};
		f.addr  = pflr_pkg::WIN_BASE + (page << pflr_pkg::PG_SHIFT) + $urandom_range(0, 8191);
		kind = $urandom_range(0, 99);
		if (kind >= 90) begin
			f.abort = 1'($urandom);
			f.fsw   = 11'($urandom);
			f.addr  = $urandom;
		end else if (kind >= 70) begin
			case ($urandom_range(0, 4))
				0: f.abort = 1'b0;
				1: f.fsw[10] = 1'b1;
				2: f.fsw[3:0] = 4'($urandom);
				3: f.addr = win_end[31:0] + $urandom_range(0, 20000);
				default: f.addr = pflr_pkg::WIN_BASE - $urandom_range(1, 20000);
			endcase
		end
		return f;
	endfunction

	task automatic queue_fault(input logic a, input logic [pflr_pkg::FSW_W-1:0] s,
	                           input logic [pflr_pkg::ADDR_W-1:0] addr);
		fault_word_t f;
		f.abort = a;
		f.fsw   = s;
		f.addr  = addr;
		fault_pending.push_back(f);
		items_issued++;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (errors < 40)
			$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	// driver: hold a word until it is taken, idle now and then
	always @(negedge clk) begin
		if (arst_n && !(s_axis_tvalid && !in_fire)) begin
			if (fault_pending.size() != 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
				drv_word = fault_pending.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {5'b0, drv_word.addr, drv_word.fsw};
				s_axis_tuser  <= drv_word.abort;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && results_seen >= 60) begin
			hold_left     <= 400;
			hold_done     <= 1'b1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= quiet || ($urandom_range(0, 99) >= 10);
		end
	end

	// monitor: check returned words, predict accepted ones, track config
	always @(posedge clk) begin
		if (arst_n) begin
			in_fire <= s_axis_tvalid && s_axis_tready;
			if (cfg_we)
				heap_pages_model = cfg_wdata;
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (m_axis_tuser)
					swaps_seen++;
				if (swaps_expected.size() == 0) begin
					report_mismatch("unexpected result word", m_axis_tdata, 0);
				end else begin
					swap_result_t e;
					e = swaps_expected.pop_front();
					if (m_axis_tuser !== e.handled)
						report_mismatch("handled", m_axis_tuser, e.handled);
					if (m_axis_tdata[4:0] !== e.victim_slot)
						report_mismatch("victim_slot", m_axis_tdata[4:0], e.victim_slot);
					if (m_axis_tdata[14:5] !== e.evicted_page)
						report_mismatch("evicted_page", m_axis_tdata[14:5], e.evicted_page);
					if (m_axis_tdata[24:15] !== e.loaded_page)
						report_mismatch("loaded_page", m_axis_tdata[24:15], e.loaded_page);
					if (m_axis_tdata[50:25] !== e.page_addr)
						report_mismatch("loaded_page_address", m_axis_tdata[50:25], e.page_addr);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				fault_word_t f;
				f.abort = s_axis_tuser;
				f.fsw   = s_axis_tdata[10:0];
				f.addr  = s_axis_tdata[42:11];
				swaps_expected.push_back(predict_fault_swap(f));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int ph, k;
		logic [31:0] wb;
		wb = pflr_pkg::WIN_BASE;
		for (k = 0; k < NSLOTS; k++)
			slot_pg[k] = k[9:0];
		for (k = 0; k < PG_MAX; k++)
			miss_cnt[k] = '0;
		heap_pages_model = pflr_pkg::HEAP_PAGES_RST;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// wait out the clearing pass
		while (!s_axis_tready) @(negedge clk);

		for (ph = 0; ph < NUM_SIZES; ph++) begin
			while (results_seen != items_issued) @(negedge clk);
			repeat (4) @(negedge clk);
			cfg_we    <= 1'b1;
			cfg_wdata <= heap_sizes[ph][pflr_pkg::CFG_W-1:0];
			@(negedge clk);
			cfg_we    <= 1'b0;
			if (ph == 0) begin
				queue_fault(1'b0, 11'h005, wb);
				queue_fault(1'b1, 11'h005, wb);
				queue_fault(1'b1, 11'h007, 32'h027F_FFFF);
				queue_fault(1'b1, 11'h405, wb);
				queue_fault(1'b1, 11'h7FF, wb);
				queue_fault(1'b1, 11'h000, wb);
				queue_fault(1'b1, 11'h3F5, wb + 32'h0000_BFFF);
				queue_fault(1'b1, 11'h007, 32'h01FF_FFFF);
				queue_fault(1'b1, 11'h007, 32'h0280_0000);
				queue_fault(1'b1, 11'h007, 32'hFFFF_FFFF);
				queue_fault(1'b1, 11'h007, 32'h0000_0000);
				queue_fault(1'b1, 11'h407, wb);
				queue_fault(1'b1, 11'h3F7, wb + 32'h0000_2000);
				// repeat a few pages so the counts drift apart
				queue_fault(1'b1, 11'h005, wb + 32'h0000_4000);
				queue_fault(1'b1, 11'h007, wb + 32'h0000_6000);
				queue_fault(1'b1, 11'h005, wb + 32'h0000_4000);
				queue_fault(1'b1, 11'h007, wb + 32'h0000_8000);
				queue_fault(1'b1, 11'h005, wb + 32'h0004_0000);
				queue_fault(1'b1, 11'h007, wb + 32'h007F_E000);
				queue_fault(1'b1, 11'h005, wb);
			end
			for (k = 0; k < ITEMS_PER_SIZE; k++) begin
				fault_pending.push_back(make_fault(heap_sizes[ph]));
				items_issued++;
			end
		end

		while (results_seen != items_issued) @(negedge clk);
		repeat (50) @(negedge clk);
		if (swaps_expected.size() != 0)
			report_mismatch("results still missing", 0, swaps_expected.size());

		$display("Ran %0d fault words over %0d heap sizes (0 and 2047 among them).",
		         items_issued, NUM_SIZES);
		$display("%0d were swaps, %0d ignored; one long output hold-off included.",
		         swaps_seen, results_seen - swaps_seen);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: page_fault_lfu_replacer.f
rtl/pflr_pkg.sv
rtl/pflr_ram.sv
rtl/pflr_min_unit.sv
rtl/page_fault_lfu_replacer.sv
rtl/pflr_checker.sv
tb/sv/tb_top.sv
